// ===== rtl/core/rbir_pkg.sv =====
// Shared types, constants, sine table and arithmetic helpers for the rigid box integrator.
`timescale 1ns / 1ps

package rbir_pkg;

    // Quarter-wave sine table
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SCL_W            = 30 + IDX_W;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint TWO_DEPTH    = 2 * SINE_TABLE_DEPTH;
    localparam int TAYLOR_TERMS     = 6;
    localparam longint TAYLOR_DIV [0:TAYLOR_TERMS-1] = '{6, 20, 42, 72, 110, 156};

    // Field and datapath widths
    localparam int DT_W      = 16;
    localparam int DATA_W    = 32;
    localparam int HALF_W    = 31;
    localparam int CORNER_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int WIDE_W    = 52;
    localparam int TRIG_W    = 16;
    localparam int STEP_W    = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXTENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y     = 2'd2;

    // Reset values
    localparam logic [HALF_W-1:0]        HALF_EXTENT_RST = 31'd2097152;
    localparam logic signed [DATA_W-1:0] POS_X_RST       = 32'sd20971520;
    localparam logic signed [DATA_W-1:0] POS_Y_RST       = 32'sd15728640;

    // Rounding and saturation constants
    localparam logic signed [PROD_W-1:0] PROD_ROUND   = PROD_W'(32768);
    localparam logic signed [WIDE_W-1:0] CORNER_ROUND = WIDE_W'(16384);
    localparam logic signed [WIDE_W-1:0] SAT_HI = {{(WIDE_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [WIDE_W-1:0] SAT_LO = {{(WIDE_W-32){1'b1}}, 32'h8000_0000};
    localparam logic [DATA_W-1:0]        QUARTER_TURN = 32'h4000_0000;

    // Microprogram step addresses
    localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL_AX  = 4'd1;
    localparam logic [STEP_W-1:0] ST_MUL_AY  = 4'd2;
    localparam logic [STEP_W-1:0] ST_PHASE   = 4'd3;
    localparam logic [STEP_W-1:0] ST_MUL_VX  = 4'd4;
    localparam logic [STEP_W-1:0] ST_MUL_VY  = 4'd5;
    localparam logic [STEP_W-1:0] ST_MUL_HC  = 4'd6;
    localparam logic [STEP_W-1:0] ST_MUL_HS  = 4'd7;
    localparam logic [STEP_W-1:0] ST_WB_Q    = 4'd8;
    localparam logic [STEP_W-1:0] ST_CORNER0 = 4'd9;
    localparam logic [STEP_W-1:0] ST_CORNER1 = 4'd10;
    localparam logic [STEP_W-1:0] ST_CORNER2 = 4'd11;
    localparam logic [STEP_W-1:0] ST_CORNER3 = 4'd12;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_OUT_FREE
    } seq_cond_t;

    typedef enum logic [2:0] {
        MA_ACCEL_X,
        MA_ACCEL_Y,
        MA_VEL_X,
        MA_VEL_Y,
        MA_HALF
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_DT,
        MB_COS,
        MB_SIN
    } mul_b_sel_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_VEL_X,
        WB_VEL_Y,
        WB_POS_X,
        WB_POS_Y,
        WB_P,
        WB_Q
    } wb_sel_t;

    typedef struct packed {
        seq_cond_t            cond;
        logic                 jump_idle;
        mul_a_sel_t           mul_a;
        mul_b_sel_t           mul_b;
        logic                 mul_en;
        wb_sel_t              wb;
        logic                 phase_en;
        logic                 trig_en;
        logic                 emit;
        logic [CORNER_W-1:0]  corner;
        logic                 last;
    } ctl_word_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } seq_status_t;

    localparam ctl_word_t CTL_NOP = '{
        cond:      COND_ALWAYS,
        jump_idle: 1'b0,
        mul_a:     MA_ACCEL_X,
        mul_b:     MB_DT,
        mul_en:    1'b0,
        wb:        WB_NONE,
        phase_en:  1'b0,
        trig_en:   1'b0,
        emit:      1'b0,
        corner:    '0,
        last:      1'b0
    };

    typedef logic [14:0] wave_tab_t [0:SINE_TABLE_DEPTH];

    // Taylor series to the x^13 term, Q2.30, rounded to Q1.15
    function automatic wave_tab_t build_wave();
        wave_tab_t tab;
        longint    x;
        longint    x2;
        longint    term;
        longint    s;
        longint    e;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (PI_Q30 * longint'(k) + longint'(SINE_TABLE_DEPTH)) / TWO_DEPTH;
            x2   = (x * x) >>> 30;
            term = x;
            s    = x;
            for (int j = 0; j < TAYLOR_TERMS; j++) begin
                term = ((term * x2) >>> 30) / TAYLOR_DIV[j];
                if (j[0] == 1'b0)
                    s = s - term;
                else
                    s = s + term;
            end
            if (s < 0)
                s = 0;
            e = (s + 16384) >>> 15;
            if (e > 32767)
                e = 32767;
            tab[k] = 15'(e);
        end
        return tab;
    endfunction

    localparam wave_tab_t WAVE_TAB = build_wave();

    // Sine of a 32-bit turn fraction, Q1.15, no interpolation
    function automatic logic signed [TRIG_W-1:0] wave(input logic [DATA_W-1:0] ph);
        logic [SCL_W-1:0]  scaled;
        logic [IDX_W-1:0]  idx;
        logic [TRIG_W-1:0] v;
        scaled = SCL_W'(ph[29:0]) * SCL_W'(SINE_TABLE_DEPTH);
        idx    = scaled[SCL_W-1:30];
        if (idx >= IDX_W'(SINE_TABLE_DEPTH))
            idx = IDX_W'(SINE_TABLE_DEPTH - 1);
        if (ph[30])
            v = {1'b0, WAVE_TAB[IDX_W'(SINE_TABLE_DEPTH) - idx]};
        else
            v = {1'b0, WAVE_TAB[idx]};
        return ph[31] ? -v : v;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        if (v > SAT_HI)
            return 32'sh7FFF_FFFF;
        else if (v < SAT_LO)
            return 32'sh8000_0000;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rbir_sequencer.sv =====
// Microcode step counter and control store for the rigid box integrator.
`timescale 1ns / 1ps

module rbir_sequencer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbir_pkg::seq_status_t status,
    output rbir_pkg::ctl_word_t   ctl,
    output logic                  go
);

    logic [rbir_pkg::STEP_W-1:0] pc_reg;
    logic [rbir_pkg::STEP_W-1:0] pc_next;

    // control store
    always_comb
    begin
        ctl = rbir_pkg::CTL_NOP;
        case (pc_reg)
            rbir_pkg::ST_IDLE:
            begin
                ctl.cond = rbir_pkg::COND_IN_VALID;
            end
            rbir_pkg::ST_MUL_AX:
            begin
                ctl.mul_a  = rbir_pkg::MA_ACCEL_X;
                ctl.mul_b  = rbir_pkg::MB_DT;
                ctl.mul_en = 1'b1;
            end
            rbir_pkg::ST_MUL_AY:
            begin
                ctl.mul_a  = rbir_pkg::MA_ACCEL_Y;
                ctl.mul_b  = rbir_pkg::MB_DT;
                ctl.mul_en = 1'b1;
                ctl.wb     = rbir_pkg::WB_VEL_X;
            end
            rbir_pkg::ST_PHASE:
            begin
                ctl.wb       = rbir_pkg::WB_VEL_Y;
                ctl.phase_en = 1'b1;
            end
            rbir_pkg::ST_MUL_VX:
            begin
                ctl.mul_a   = rbir_pkg::MA_VEL_X;
                ctl.mul_b   = rbir_pkg::MB_DT;
                ctl.mul_en  = 1'b1;
                ctl.trig_en = 1'b1;
            end
            rbir_pkg::ST_MUL_VY:
            begin
                ctl.mul_a  = rbir_pkg::MA_VEL_Y;
                ctl.mul_b  = rbir_pkg::MB_DT;
                ctl.mul_en = 1'b1;
                ctl.wb     = rbir_pkg::WB_POS_X;
            end
            rbir_pkg::ST_MUL_HC:
            begin
                ctl.mul_a  = rbir_pkg::MA_HALF;
                ctl.mul_b  = rbir_pkg::MB_COS;
                ctl.mul_en = 1'b1;
                ctl.wb     = rbir_pkg::WB_POS_Y;
            end
            rbir_pkg::ST_MUL_HS:
            begin
                ctl.mul_a  = rbir_pkg::MA_HALF;
                ctl.mul_b  = rbir_pkg::MB_SIN;
                ctl.mul_en = 1'b1;
                ctl.wb     = rbir_pkg::WB_P;
            end
            rbir_pkg::ST_WB_Q:
            begin
                ctl.wb = rbir_pkg::WB_Q;
            end
            rbir_pkg::ST_CORNER0:
            begin
                ctl.cond   = rbir_pkg::COND_OUT_FREE;
                ctl.emit   = 1'b1;
                ctl.corner = 2'd0;
            end
            rbir_pkg::ST_CORNER1:
            begin
                ctl.cond   = rbir_pkg::COND_OUT_FREE;
                ctl.emit   = 1'b1;
                ctl.corner = 2'd1;
            end
            rbir_pkg::ST_CORNER2:
            begin
                ctl.cond   = rbir_pkg::COND_OUT_FREE;
                ctl.emit   = 1'b1;
                ctl.corner = 2'd2;
            end
            rbir_pkg::ST_CORNER3:
            begin
                ctl.cond      = rbir_pkg::COND_OUT_FREE;
                ctl.emit      = 1'b1;
                ctl.corner    = 2'd3;
                ctl.last      = 1'b1;
                ctl.jump_idle = 1'b1;
            end
            default:
            begin
                ctl.jump_idle = 1'b1;
            end
        endcase
    end

    // step condition
    always_comb
    begin
        case (ctl.cond)
            rbir_pkg::COND_ALWAYS:   go = 1'b1;
            rbir_pkg::COND_IN_VALID: go = status.in_valid;
            rbir_pkg::COND_OUT_FREE: go = status.out_free;
            default:                 go = 1'b1;
        endcase
    end

    // next step
    always_comb
    begin
        if (!go)
            pc_next = pc_reg;
        else if (ctl.jump_idle)
            pc_next = rbir_pkg::ST_IDLE;
        else
            pc_next = pc_reg + rbir_pkg::STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= rbir_pkg::ST_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== rtl/core/rbir_datapath.sv =====
// Shared multiplier, body state, sine/cosine lookup and corner adder.
`timescale 1ns / 1ps

module rbir_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rbir_pkg::ctl_word_t                  ctl,
    input  logic                                 go,
    input  logic [rbir_pkg::DT_W-1:0]            delta_time,
    input  logic [rbir_pkg::HALF_W-1:0]          half_extent,
    input  logic signed [rbir_pkg::DATA_W-1:0]   accel_x,
    input  logic signed [rbir_pkg::DATA_W-1:0]   accel_y,
    output logic signed [rbir_pkg::DATA_W-1:0]   corner_x,
    output logic signed [rbir_pkg::DATA_W-1:0]   corner_y
);

    logic [rbir_pkg::DT_W-1:0]              dt_reg;
    logic signed [rbir_pkg::PROD_W-1:0]     prod_reg;
    logic signed [rbir_pkg::PROD_W-1:0]     p_reg;
    logic signed [rbir_pkg::PROD_W-1:0]     q_reg;
    logic signed [rbir_pkg::TRIG_W-1:0]     sin_reg;
    logic signed [rbir_pkg::TRIG_W-1:0]     cos_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     vel_x_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     vel_y_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     pos_x_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     pos_y_reg;
    logic [rbir_pkg::DATA_W-1:0]            heading_reg;

    logic signed [rbir_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [rbir_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [rbir_pkg::PROD_W-1:0]     product;
    logic signed [rbir_pkg::PROD_W-1:0]     rnd;
    logic signed [rbir_pkg::DATA_W-1:0]     acc_base;
    logic signed [rbir_pkg::DATA_W-1:0]     acc_sum;
    logic                                   load_dt;
    logic                                   step_en;

    logic                                   sx_pos;
    logic                                   sy_pos;
    logic signed [rbir_pkg::WIDE_W-1:0]     p_wide;
    logic signed [rbir_pkg::WIDE_W-1:0]     q_wide;
    logic signed [rbir_pkg::WIDE_W-1:0]     wx;
    logic signed [rbir_pkg::WIDE_W-1:0]     wy;

    assign load_dt = go && (ctl.cond == rbir_pkg::COND_IN_VALID);
    assign step_en = go && (ctl.cond == rbir_pkg::COND_ALWAYS);

    // operand select
    always_comb
    begin
        case (ctl.mul_a)
            rbir_pkg::MA_ACCEL_X: mul_a = rbir_pkg::MUL_A_W'(accel_x);
            rbir_pkg::MA_ACCEL_Y: mul_a = rbir_pkg::MUL_A_W'(accel_y);
            rbir_pkg::MA_VEL_X:   mul_a = rbir_pkg::MUL_A_W'(vel_x_reg);
            rbir_pkg::MA_VEL_Y:   mul_a = rbir_pkg::MUL_A_W'(vel_y_reg);
            rbir_pkg::MA_HALF:    mul_a = {2'b00, half_extent};
            default:              mul_a = '0;
        endcase
        case (ctl.mul_b)
            rbir_pkg::MB_DT:  mul_b = {1'b0, dt_reg};
            rbir_pkg::MB_COS: mul_b = rbir_pkg::MUL_B_W'(cos_reg);
            rbir_pkg::MB_SIN: mul_b = rbir_pkg::MUL_B_W'(sin_reg);
            default:          mul_b = '0;
        endcase
    end

    assign product = mul_a * mul_b;

    // round half up to Q16.16, then accumulate with saturation
    assign rnd = (prod_reg + rbir_pkg::PROD_ROUND) >>> 16;

    always_comb
    begin
        case (ctl.wb)
            rbir_pkg::WB_VEL_X: acc_base = vel_x_reg;
            rbir_pkg::WB_VEL_Y: acc_base = vel_y_reg;
            rbir_pkg::WB_POS_X: acc_base = pos_x_reg;
            rbir_pkg::WB_POS_Y: acc_base = pos_y_reg;
            default:            acc_base = '0;
        endcase
    end

    assign acc_sum = rbir_pkg::sat32(rbir_pkg::WIDE_W'(acc_base) + rbir_pkg::WIDE_W'(rnd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            pos_x_reg   <= rbir_pkg::POS_X_RST;
            pos_y_reg   <= rbir_pkg::POS_Y_RST;
            heading_reg <= '0;
        end
        else if (step_en)
        begin
            case (ctl.wb)
                rbir_pkg::WB_VEL_X: vel_x_reg <= acc_sum;
                rbir_pkg::WB_VEL_Y: vel_y_reg <= acc_sum;
                rbir_pkg::WB_POS_X: pos_x_reg <= acc_sum;
                rbir_pkg::WB_POS_Y: pos_y_reg <= acc_sum;
                default:            ;
            endcase
            if (ctl.phase_en)
                heading_reg <= heading_reg + {3'b000, dt_reg, 13'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_dt)
            dt_reg <= delta_time;
        if (step_en && ctl.mul_en)
            prod_reg <= product;
        if (step_en && ctl.wb == rbir_pkg::WB_P)
            p_reg <= prod_reg;
        if (step_en && ctl.wb == rbir_pkg::WB_Q)
            q_reg <= prod_reg;
        if (step_en && ctl.trig_en)
        begin
            sin_reg <= rbir_pkg::wave(heading_reg);
            cos_reg <= rbir_pkg::wave(heading_reg + rbir_pkg::QUARTER_TURN);
        end
    end

    // corner: P = h*cos, Q = h*sin, signs picked per corner
    assign sx_pos = (ctl.corner == 2'd1) || (ctl.corner == 2'd2);
    assign sy_pos = (ctl.corner == 2'd2) || (ctl.corner == 2'd3);
    assign p_wide = rbir_pkg::WIDE_W'(p_reg);
    assign q_wide = rbir_pkg::WIDE_W'(q_reg);

    assign wx = (sx_pos ? p_wide : -p_wide) + (sy_pos ? -q_wide : q_wide)
              + (rbir_pkg::WIDE_W'(pos_x_reg) <<< 15) + rbir_pkg::CORNER_ROUND;
    assign wy = (sx_pos ? q_wide : -q_wide) + (sy_pos ? p_wide : -p_wide)
              + (rbir_pkg::WIDE_W'(pos_y_reg) <<< 15) + rbir_pkg::CORNER_ROUND;

    assign corner_x = rbir_pkg::sat32(wx >>> 15);
    assign corner_y = rbir_pkg::sat32(wy >>> 15);

endmodule

// ===== rtl/core/rigid_box_integrate_rotate.sv =====
// Top level: rigid box integrator with rotated corner output.
// Each request of one dt runs a 13-step microprogram on one shared 33x17 multiplier.
// After the accepting edge the microprogram runs its multiply and writeback steps, then emits
// one corner per cycle while the output slot is free; tready high only in idle.
// Reset (async, active low): sequencer to idle, output empty, velocity 0, position (320,240),
// heading 0, half extent 32.0, acceleration 0. The sine table is constant.
`timescale 1ns / 1ps

module rigid_box_integrate_rotate
(
    input  logic        clk,
    input  logic        rst_n,

    // request: [15:0] delta_time
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,

    // corner: [1:0] corner_index, [33:2] corner_x, [65:34] corner_y, [71:66] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tlast,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // config registers
    logic [rbir_pkg::HALF_W-1:0]            half_extent_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     accel_x_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     accel_y_reg;

    // output register
    logic                                   out_valid_reg;
    logic [rbir_pkg::CORNER_W-1:0]          out_index_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     out_x_reg;
    logic signed [rbir_pkg::DATA_W-1:0]     out_y_reg;
    logic                                   out_last_reg;

    rbir_pkg::ctl_word_t                    ctl;
    rbir_pkg::seq_status_t                  status;
    logic                                   go;
    logic                                   emit_fire;
    logic                                   s_fire;
    logic                                   m_fire;
    logic signed [rbir_pkg::DATA_W-1:0]     corner_x;
    logic signed [rbir_pkg::DATA_W-1:0]     corner_y;

    // output slot is free when empty or being drained this cycle
    assign status.in_valid = s_axis_tvalid;
    assign status.out_free = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (ctl.cond == rbir_pkg::COND_IN_VALID);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_fire        = m_axis_tvalid && m_axis_tready;
    assign emit_fire     = ctl.emit && go;

    rbir_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl),
        .go     (go)
    );

    rbir_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .go          (go),
        .delta_time  (s_axis_tdata),
        .half_extent (half_extent_reg),
        .accel_x     (accel_x_reg),
        .accel_y     (accel_y_reg),
        .corner_x    (corner_x),
        .corner_y    (corner_y)
    );

    // config writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_extent_reg <= rbir_pkg::HALF_EXTENT_RST;
            accel_x_reg     <= '0;
            accel_y_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbir_pkg::CFG_HALF_EXTENT: half_extent_reg <= cfg_data[rbir_pkg::HALF_W-1:0];
                rbir_pkg::CFG_ACCEL_X:     accel_x_reg     <= cfg_data;
                rbir_pkg::CFG_ACCEL_Y:     accel_y_reg     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // output stage: valid flag under reset, payload loads on emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_fire)
            out_valid_reg <= 1'b1;
        else if (m_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_index_reg <= ctl.corner;
            out_x_reg     <= corner_x;
            out_y_reg     <= corner_y;
            out_last_reg  <= ctl.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'b000000, out_y_reg, out_x_reg, out_index_reg};

    // last flag marks exactly the fourth corner
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd3)))
        else $error("tlast does not match corner index");

    // one request at a time: no new request right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    // a corner may overwrite a full output slot only when it drains that cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && out_valid_reg) |-> m_axis_tready)
        else $error("corner overwrote a pending output");

    // no corner is emitted while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !emit_fire)
        else $error("corner emitted in idle step");

endmodule

// ===== tb/tb_rigid_box_integrate_rotate.sv =====
// Testbench for the rigid box integrator: stepped requests, predicted and checked corners.
`timescale 1ns / 1ps

module tb_rigid_box_integrate_rotate;

    // Index 3 of the config port maps to no register; writes there must be dropped.
    localparam logic [1:0] CFG_NO_REG = 2'd3;

    // pi in Q2.30, seed of the quarter-wave table
    localparam longint PI_Q2_30  = 64'sd3373259426;
    localparam int     WAVE_SIZE = 256;
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [1:0]         index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } corner_t;

    // ---------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ---------------------------------------------------------------
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] delta_time
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [1:0] index, [33:2] x, [65:34] y, [71:66] zero
    logic        m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;

    rigid_box_integrate_rotate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow of the body: config registers and integrator state
    // ---------------------------------------------------------------
    logic [30:0]        half_q    = 31'd2097152;
    logic signed [31:0] accel_x_q = '0;
    logic signed [31:0] accel_y_q = '0;
    longint             vel_x     = 0;
    longint             vel_y     = 0;
    longint             pos_x     = 64'sd320 <<< 16;
    longint             pos_y     = 64'sd240 <<< 16;
    logic [31:0]        heading   = '0;
    longint             sine_quarter [0:WAVE_SIZE];

    corner_t     expected_corners [$];
    logic [15:0] pending_dt [$];

    int  items_queued   = 0;
    int  steps_accepted = 0;
    int  corners_seen   = 0;
    int  mismatch_count = 0;
    int  stray_count    = 0;
    int  phase_no       = 0;
    bit  idle_on        = 1'b1;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Q1.15 sine of a turn fraction: quadrant in the top two bits, no interpolation
    function automatic longint turn_sine(input logic [31:0] ph);
        int     slot;
        longint mag;
        slot = int'(ph[29:22]);
        mag  = ph[30] ? sine_quarter[WAVE_SIZE - slot] : sine_quarter[slot];
        return ph[31] ? -mag : mag;
    endfunction

    // Gap length for either side: none when idling is off; else half none, most of the rest short, a few long
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One semi-implicit Euler step, then the four corners it yields
    task automatic integrate_step(input logic [15:0] dt);
        longint  d;
        longint  s;
        longint  c;
        longint  h;
        longint  bx;
        longint  by;
        longint  wx;
        longint  wy;
        corner_t r;
        d = longint'(dt);
        // velocity first, then position from the new velocity
        vel_x = clamp32(vel_x + ((longint'(accel_x_q) * d + 32768) >>> 16));
        vel_y = clamp32(vel_y + ((longint'(accel_y_q) * d + 32768) >>> 16));
        pos_x = clamp32(pos_x + ((vel_x * d + 32768) >>> 16));
        pos_y = clamp32(pos_y + ((vel_y * d + 32768) >>> 16));
        // 1/8 turn per second: dt in Q0.16 scaled by 2^13
        heading = heading + {3'b000, dt, 13'b0};
        s = turn_sine(heading);
        c = turn_sine(heading + PHASE_QUARTER);
        h = longint'(half_q);
        for (int k = 0; k < 4; k++)
        begin
            bx = (k == 0 || k == 3) ? -h : h;
            by = (k < 2) ? -h : h;
            wx = bx * c - by * s + pos_x * 32768;
            wy = bx * s + by * c + pos_y * 32768;
            r.index = 2'(k);
            r.x     = 32'(clamp32((wx + 16384) >>> 15));
            r.y     = 32'(clamp32((wy + 16384) >>> 15));
            r.last  = (k == 3);
            expected_corners.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------
    // Request driver: offers queued dt values with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                integrate_step(s_axis_tdata);
                steps_accepted <= steps_accepted + 1;
            end
            // the slot is free after this edge unless a request is still waiting
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_dt.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_dt.pop_front();
                    send_gap      <= pick_gap();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Corner receiver: random ready, plus one long hold-off
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
            m_axis_tready <= 1'b0;
        else if (recv_gap != 0)
        begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            recv_gap      <= pick_gap();
        end
    end

    // Once 60 steps are in, hold the output off so the block backs up and
    // stalls its input while requests keep being offered.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && steps_accepted >= 60)
            begin
                hold_left <= 400;
                hold_done <= 1'b1;
            end
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Corner monitor: compare against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        corner_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            corners_seen <= corners_seen + 1;
            if (expected_corners.size() == 0)
            begin
                stray_count = stray_count + 1;
                if (mismatch_count + stray_count <= MAX_REPORTS)
                    $display("unexpected corner: idx %0d x %08h y %08h",
                             m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34]);
            end
            else
            begin
                want = expected_corners.pop_front();
                if (m_axis_tdata[1:0] !== want.index || m_axis_tdata[33:2] !== want.x ||
                    m_axis_tdata[65:34] !== want.y || m_axis_tlast !== want.last ||
                    m_axis_tdata[71:66] !== 6'd0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count + stray_count <= MAX_REPORTS)
                        $display("corner mismatch (phase %0d): want idx %0d x %08h y %08h last %0b%s",
                                 phase_no, want.index, want.x, want.y, want.last, "");
                    if (mismatch_count + stray_count <= MAX_REPORTS)
                        $display("    got idx %0d x %08h y %08h last %0b pad %02h",
                                 m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[65:34],
                                 m_axis_tlast, m_axis_tdata[71:66]);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            rbir_pkg::CFG_HALF_EXTENT: half_q    = value[30:0];   // top bit dropped
            rbir_pkg::CFG_ACCEL_X:     accel_x_q = value;
            rbir_pkg::CFG_ACCEL_Y:     accel_y_q = value;
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_step(input logic [15:0] dt);
        pending_dt.push_back(dt);
        items_queued = items_queued + 1;
    endtask

    // Block is idle once every request is in and every corner is out
    task automatic wait_drained();
        while (steps_accepted != items_queued || expected_corners.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            // a quarter of the steps short, so the heading also creeps slowly
            if ($urandom_range(0, 3) == 0)
                queue_step(16'($urandom_range(0, 255)));
            else
                queue_step(16'($urandom_range(0, 65535)));
        end
    endtask

    function automatic logic [31:0] moderate_accel();
        // roughly +/-100.0 units/s^2
        return 32'($urandom_range(0, 200 * 65536)) - 32'(100 * 65536);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        longint x;
        longint x2;
        longint term;
        longint acc;

        // quarter-wave table: Taylor series to x^13, truncating steps
        for (int k = 0; k <= WAVE_SIZE; k++)
        begin
            x    = (PI_Q2_30 * longint'(k) + WAVE_SIZE) / (2 * WAVE_SIZE);
            x2   = (x * x) >>> 30;
            term = x;
            acc  = x;
            for (int n = 3; n <= 13; n += 2)
            begin
                term = ((term * x2) >>> 30) / longint'(n * (n - 1));
                if (((n - 3) / 2) % 2 == 0)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 16384) >>> 15;
            sine_quarter[k] = (acc > 32767) ? 32767 : acc;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 0: reset config. Zero steps, extremes of dt, alternating bits,
        // and a run of full-length steps that carries the heading past a full turn.
        phase_no = 0;
        queue_step(16'h0000);
        queue_step(16'h0001);
        queue_step(16'hFFFF);
        queue_step(16'h0000);
        queue_step(16'h5555);
        queue_step(16'hAAAA);
        queue_step(16'h8000);
        for (int i = 0; i < 10; i++)
            queue_step(16'hFFFF);
        wait_drained();

        // Phase 1: write to the unmapped index (must change nothing), point body
        phase_no = 1;
        write_reg(CFG_NO_REG, 32'h1234_5678);
        write_reg(rbir_pkg::CFG_HALF_EXTENT, 32'h0000_0000);
        write_reg(rbir_pkg::CFG_ACCEL_X, 32'h0001_8000);
        write_reg(rbir_pkg::CFG_ACCEL_Y, 32'hFFFF_4000);
        close_writes();
        queue_step(16'h0000);
        queue_step(16'hFFFF);
        queue_step(16'h4000);
        queue_step(16'h0001);
        wait_drained();

        // Phase 2: everyday sizes and accelerations; the long output hold-off lands here
        phase_no = 2;
        write_reg(rbir_pkg::CFG_HALF_EXTENT, 32'($urandom_range(0, 200 * 65536)));
        write_reg(rbir_pkg::CFG_ACCEL_X, moderate_accel());
        write_reg(rbir_pkg::CFG_ACCEL_Y, moderate_accel());
        close_writes();
        queue_random(150);
        wait_drained();

        // Phase 3: all ones into half extent (top bit dropped), no acceleration;
        // corners run into saturation
        phase_no = 3;
        write_reg(rbir_pkg::CFG_HALF_EXTENT, 32'hFFFF_FFFF);
        write_reg(rbir_pkg::CFG_ACCEL_X, 32'h0000_0000);
        write_reg(rbir_pkg::CFG_ACCEL_Y, 32'h0000_0000);
        close_writes();
        queue_random(40);
        wait_drained();

        // Phase 4: full-range random registers, no idling on either side
        phase_no = 4;
        idle_on  = 1'b0;
        write_reg(rbir_pkg::CFG_HALF_EXTENT, $urandom());
        write_reg(rbir_pkg::CFG_ACCEL_X, $urandom());
        write_reg(rbir_pkg::CFG_ACCEL_Y, $urandom());
        close_writes();
        queue_random(100);
        wait_drained();
        idle_on = 1'b1;

        // Phase 5: largest acceleration; velocity and position pin at the top
        phase_no = 5;
        write_reg(rbir_pkg::CFG_HALF_EXTENT, 32'($urandom_range(0, 1000 * 65536)));
        write_reg(rbir_pkg::CFG_ACCEL_X, 32'h7FFF_FFFF);
        write_reg(rbir_pkg::CFG_ACCEL_Y, 32'h7FFF_FFFF);
        close_writes();
        queue_step(16'hFFFF);
        queue_random(40);
        wait_drained();

        // Phase 6: most negative acceleration drives everything to the bottom
        phase_no = 6;
        write_reg(rbir_pkg::CFG_ACCEL_X, 32'h8000_0000);
        write_reg(rbir_pkg::CFG_ACCEL_Y, 32'h8000_0000);
        close_writes();
        queue_step(16'hFFFF);
        queue_random(40);
        wait_drained();

        // Phase 7: small body, gentle opposite pulls to ease off the rails
        phase_no = 7;
        write_reg(rbir_pkg::CFG_HALF_EXTENT, 32'($urandom_range(1, 16 * 65536)));
        write_reg(rbir_pkg::CFG_ACCEL_X, moderate_accel());
        write_reg(rbir_pkg::CFG_ACCEL_Y, moderate_accel());
        close_writes();
        queue_random(30);
        wait_drained();

        $display("run covered %0d steps over %0d config phases, %0d corners compared",
                 steps_accepted, phase_no + 1, corners_seen);
        $display("corner mismatches %0d, unexpected corners %0d, still pending %0d",
                 mismatch_count, stray_count, expected_corners.size());
        if (mismatch_count == 0 && stray_count == 0 && expected_corners.size() == 0)
            $display("tb_rigid_box_integrate_rotate passed");
        else
            $display("tb_rigid_box_integrate_rotate failed");
        $finish;
    end

    // Generous ceiling, far beyond the slowest stalled run
    initial
    begin
        #(4_000_000);
        $display("timeout: %0d of %0d steps accepted, %0d corners pending",
                 steps_accepted, items_queued, expected_corners.size());
        $display("tb_rigid_box_integrate_rotate failed");
        $finish;
    end

endmodule
